// ----- design/skt_pkg.sv -----
// Package for the sorted key table: payload types, request, status and cell codes.
`timescale 1ns / 1ps
package skt_pkg;

    // Request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_FIND   = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_DUP       = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

    // Cell operation codes
    typedef logic [1:0] cell_op_t;
    localparam cell_op_t CELL_HOLD = 2'd0;
    localparam cell_op_t CELL_CMP  = 2'd1;
    localparam cell_op_t CELL_INS  = 2'd2;
    localparam cell_op_t CELL_DEL  = 2'd3;

    // Control word broadcast from the sequencer to every cell
    typedef struct packed {
        cell_op_t op;
    } cell_ctrl_t;

    // Input word
    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] key;
    } skt_req_t;

    // Result word
    typedef struct packed {
        logic [1:0] status;
        logic [3:0] position;
        logic [4:0] entry_count;
        logic       is_full;
        logic       is_empty;
    } skt_rsp_t;

endpackage

// ----- design/sorted_key_table.sv -----
// Top level of the sorted key table: request sequencer, cell chain and result register.
//
// Usage: a request word (req_type, key) enters on s_valid/s_ready; one result word
// (status, position, entry_count, is_full, is_empty) leaves on m_valid/m_ready for
// every request. Keys are held in ascending order in a chain of CAPACITY cells, one
// key per cell. The request key is broadcast to all cells, which compare in parallel;
// on an insert or remove every cell at or above the slot moves one key to or from
// its neighbor in the same cycle.
// Sequence: an accepted request passes through the compare step and then the update
// step, which registers its result for m_valid. A new request is accepted only once
// the sequencer is idle again, after the previous result has been registered.
// When the receiver stalls, the update step of the next request waits until the
// result register is free; the table is not touched meanwhile.
// Reset (aresetn low, synchronous) empties the table and drops any pending result;
// no clearing pass is needed, as slots at or above the count are never read.
`timescale 1ns / 1ps
module sorted_key_table #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  skt_pkg::skt_req_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output skt_pkg::skt_rsp_t m_data
);
    import skt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = (CNT_W > 5) ? CNT_W : 5;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [1:0]          req_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_in;
    logic                m_valid_reg;
    skt_rsp_t            rsp_reg, rsp_next;
    cell_ctrl_t          ctrl;

    logic [KEY_BITS-1:0] cell_key [CAPACITY];
    logic [CAPACITY-1:0] cell_lt;
    logic [CAPACITY-1:0] cell_eq;
    logic [CAPACITY-1:0] cell_valid;
    logic [CAPACITY-1:0] at_slot;

    logic                present;
    logic                is_full_now;
    logic                commit;
    logic                shift_ok;
    logic [3:0]          pos_slot;
    logic [EXT_W-1:0]    cnt_ext;

    // Fit the incoming key to KEY_BITS: truncate it or zero-extend it
    generate
        if (KEY_BITS > 16) begin : g_key_wide
            assign key_in = {{(KEY_BITS - 16){1'b0}}, s_data.key};
        end else if (KEY_BITS == 16) begin : g_key_same
            assign key_in = s_data.key;
        end else begin : g_key_narrow
            assign key_in = s_data.key[KEY_BITS-1:0];
        end
    endgenerate

    // Build the cell chain
    generate
        for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
            localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
            logic                left_lt;
            logic [KEY_BITS-1:0] left_key;
            logic [KEY_BITS-1:0] right_key;

            assign cell_valid[i] = IDX < count_reg;

            if (i == 0) begin : g_first
                assign left_lt    = 1'b1;
                assign left_key   = key_reg;
                assign at_slot[i] = !cell_lt[i];
            end else begin : g_rest
                assign left_lt    = cell_lt[i-1];
                assign left_key   = cell_key[i-1];
                assign at_slot[i] = !cell_lt[i] && cell_lt[i-1];
            end

            if (i == CAPACITY - 1) begin : g_last
                assign right_key = cell_key[i];
            end else begin : g_inner
                assign right_key = cell_key[i+1];
            end

            skt_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .in_key    (key_reg),
                .in_valid  (cell_valid[i]),
                .left_lt   (left_lt),
                .left_key  (left_key),
                .right_key (right_key),
                .out_key   (cell_key[i]),
                .out_lt    (cell_lt[i]),
                .out_eq    (cell_eq[i])
            );
        end
    endgenerate

    // Encode the slot where the key sits or would go
    always_comb begin
        pos_slot = 4'd0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (at_slot[i]) begin
                pos_slot = pos_slot | 4'(i);
            end
        end
    end

    assign present     = |cell_eq;
    assign is_full_now = (count_reg == CNT_W'(CAPACITY));
    assign commit      = (state_reg == S_UPD) && (!m_valid_reg || m_ready);

    // Decide status, new count and whether the chain shifts
    always_comb begin
        shift_ok   = 1'b0;
        count_next = count_reg;
        rsp_next   = '0;
        case (req_reg)
            REQ_INSERT: begin
                if (is_full_now) begin
                    rsp_next.status = STAT_FULL;
                end else if (present) begin
                    rsp_next.status = STAT_DUP;
                end else begin
                    rsp_next.status   = STAT_OK;
                    rsp_next.position = pos_slot;
                    shift_ok          = 1'b1;
                    count_next        = count_reg + 1'b1;
                end
            end
            REQ_REMOVE: begin
                if (!present) begin
                    rsp_next.status = STAT_NOT_FOUND;
                end else begin
                    rsp_next.status   = STAT_OK;
                    rsp_next.position = pos_slot;
                    shift_ok          = 1'b1;
                    count_next        = count_reg - 1'b1;
                end
            end
            default: begin
                if (!present) begin
                    rsp_next.status = STAT_NOT_FOUND;
                end else begin
                    rsp_next.status   = STAT_OK;
                    rsp_next.position = pos_slot;
                end
            end
        endcase
        cnt_ext              = EXT_W'(count_next);
        rsp_next.entry_count = cnt_ext[4:0];
        rsp_next.is_full     = (count_next == CNT_W'(CAPACITY));
        rsp_next.is_empty    = (count_next == '0);
    end

    // Drive the cell chain
    always_comb begin
        ctrl.op = CELL_HOLD;
        case (state_reg)
            S_CMP: begin
                ctrl.op = CELL_CMP;
            end
            S_UPD: begin
                if (commit && shift_ok) begin
                    ctrl.op = (req_reg == REQ_INSERT) ? CELL_INS : CELL_DEL;
                end
            end
            default: begin
                ctrl.op = CELL_HOLD;
            end
        endcase
    end

    // Advance the sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                state_next = S_UPD;
            end
            S_UPD: begin
                if (commit) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (commit) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the request word and the result word
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data.req_type;
            key_reg <= key_in;
        end
        if (commit) begin
            rsp_reg <= rsp_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = rsp_reg;

endmodule

// ----- design/skt_cell.sv -----
// One slot of the sorted key chain: holds a key, compares it and shifts with its neighbors.
`timescale 1ns / 1ps
module skt_cell #(
    parameter int KEY_BITS = 16
) (
    input  logic                  aclk,
    input  skt_pkg::cell_ctrl_t   ctrl,
    input  logic [KEY_BITS-1:0]   in_key,
    input  logic                  in_valid,
    input  logic                  left_lt,
    input  logic [KEY_BITS-1:0]   left_key,
    input  logic [KEY_BITS-1:0]   right_key,
    output logic [KEY_BITS-1:0]   out_key,
    output logic                  out_lt,
    output logic                  out_eq
);
    import skt_pkg::*;

    logic [KEY_BITS-1:0] key_reg;
    logic                lt_reg;
    logic                eq_reg;

    // Compare against the broadcast key, or shift by one slot
    always_ff @(posedge aclk) begin
        case (ctrl.op)
            CELL_CMP: begin
                lt_reg <= in_valid && (key_reg < in_key);
                eq_reg <= in_valid && (key_reg == in_key);
            end
            CELL_INS: begin
                if (!lt_reg) begin
                    key_reg <= left_lt ? in_key : left_key;
                end
            end
            CELL_DEL: begin
                if (!lt_reg) begin
                    key_reg <= right_key;
                end
            end
            default: begin
            end
        endcase
    end

    assign out_key = key_reg;
    assign out_lt  = lt_reg;
    assign out_eq  = eq_reg;

endmodule
